FILE: hw/rtl/wfd_pkg.sv
`timescale 1ns / 1ps

package wfd_pkg;

    // Longest supported frame, and the key slice presented on the output
    localparam int FRAME_BITS = 80;
    localparam int POS_W      = 7;
    localparam int FMT_W      = 3;
    localparam int STATUS_W   = 2;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // frame_format codes
    localparam logic [FMT_W-1:0] FMT_26      = 3'd0;
    localparam logic [FMT_W-1:0] FMT_32      = 3'd1;
    localparam logic [FMT_W-1:0] FMT_34      = 3'd2;
    localparam logic [FMT_W-1:0] FMT_35      = 3'd3;
    localparam logic [FMT_W-1:0] FMT_37      = 3'd4;
    localparam logic [FMT_W-1:0] FMT_64      = 3'd5;
    localparam logic [FMT_W-1:0] FMT_80      = 3'd6;
    localparam logic [FMT_W-1:0] FMT_UNKNOWN = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PARITY_FAIL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FORMAT  = 2'd2;

    // Frame length in bits for a format; zero for the unknown format
    function automatic logic [POS_W-1:0] fmt_len(input logic [FMT_W-1:0] fmt);
        logic [POS_W-1:0] len;
        case (fmt)
            FMT_26:  len = 7'd26;
            FMT_32:  len = 7'd32;
            FMT_34:  len = 7'd34;
            FMT_35:  len = 7'd35;
            FMT_37:  len = 7'd37;
            FMT_64:  len = 7'd64;
            FMT_80:  len = 7'd80;
            default: len = 7'd0;
        endcase
        return len;
    endfunction

    // Formats framed by a leading and a trailing parity bit
    function automatic logic fmt_has_parity(input logic [FMT_W-1:0] fmt);
        logic par;
        case (fmt)
            FMT_26, FMT_34, FMT_35, FMT_37: par = 1'b1;
            default:                        par = 1'b0;
        endcase
        return par;
    endfunction

endpackage

FILE: hw/rtl/wfd_in_if.sv
`timescale 1ns / 1ps

interface wfd_in_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic frame_end;

    modport source (output valid, output data_bit, output frame_end, input ready);
    modport sink   (input valid, input data_bit, input frame_end, output ready);
endinterface

FILE: hw/rtl/wfd_out_if.sv
`timescale 1ns / 1ps

interface wfd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] key_high;
    logic [63:0] key_low;
    logic [1:0]  status;

    modport source (output valid, output key_high, output key_low, output status,
                    input ready);
    modport sink   (input valid, input key_high, input key_low, input status,
                    output ready);
endinterface

FILE: hw/rtl/wfd_cfg_if.sv
`timescale 1ns / 1ps

interface wfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] frame_format;

    modport source (output valid, output frame_format, input ready);
    modport sink   (input valid, input frame_format, output ready);
endinterface

FILE: hw/rtl/wiegand_frame_decoder_top.sv
`timescale 1ns / 1ps
// The key is registered: a final bit passes the input register, then the
// result register, before key.valid rises.
// Throughput: one bit transaction per cycle; a final bit waits only while an
// unaccepted key holds the result register.
// Reset (rst_n low, asynchronous): frame state, format register and both valid
// flags clear; the format returns to 26-bit.
module wiegand_frame_decoder_top (
    input  logic           clk,
    input  logic           rst_n,
    wfd_cfg_if.sink        cfg,
    wfd_in_if.sink         frame,
    wfd_out_if.source      key
);
    import wfd_pkg::*;

    // Configuration
    logic [FMT_W-1:0] format_reg;

    // Input register stage
    logic s1_valid_reg;
    logic s1_bit_reg;
    logic s1_end_reg;

    // Frame state
    logic [POS_W-1:0]      pos_reg,    pos_next;
    logic [0:FRAME_BITS-1] frame_reg,  frame_next;   // index = bit position
    logic                  parity_reg, parity_next;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    logic [0:FRAME_BITS-1] key_reg,       key_next;
    logic [STATUS_W-1:0]   status_reg,    status_next;

    // Handshake
    logic out_free;
    logic s1_go;
    logic frame_take;

    // Per-bit working values
    logic [POS_W-1:0]      len;
    logic                  has_par;
    logic                  store_bit;
    logic [0:FRAME_BITS-1] frame_upd;
    logic [0:FRAME_BITS-1] frame_shift;
    logic                  parity_upd;
    logic [POS_W-1:0]      keep_n;
    logic [0:FRAME_BITS-1] payload;

    // Config register is always writable
    assign cfg.ready = 1'b1;

    // The output slot is free when empty or being drained this cycle.
    // A final bit waits in the input register until the slot is free;
    // other bits advance unconditionally.
    assign out_free   = !out_valid_reg || key.ready;
    assign s1_go      = s1_valid_reg && (!s1_end_reg || out_free);
    assign frame.ready = !s1_valid_reg || s1_go;
    assign frame_take = frame.valid && frame.ready;

    assign len     = fmt_len(format_reg);
    assign has_par = fmt_has_parity(format_reg);

    // Drop bits past the format length; the XOR of all stored bits equals
    // first-half parity XOR second-half parity, so one bit tracks the check.
    assign store_bit  = s1_bit_reg && (pos_reg < len);
    assign parity_upd = parity_reg ^ store_bit;

    always_comb
    begin
        for (int i = 0; i < FRAME_BITS; i++)
        begin
            frame_upd[i] = frame_reg[i] | (store_bit && (pos_reg == POS_W'(i)));
        end
    end

    // Parity formats lose the leading and trailing bit: shift up by one and
    // keep len-2 bits. Other formats keep len bits; a format changed
    // mid-frame can leave stored bits past that length.
    assign frame_shift = frame_upd << 1;
    assign keep_n      = has_par ? (len - POS_W'(2)) : len;

    always_comb
    begin
        for (int i = 0; i < FRAME_BITS; i++)
        begin
            if (POS_W'(i) < keep_n)
            begin
                payload[i] = has_par ? frame_shift[i] : frame_upd[i];
            end
            else
            begin
                payload[i] = 1'b0;
            end
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        frame_next     = frame_reg;
        parity_next    = parity_reg;
        out_valid_next = out_valid_reg && !key.ready;
        key_next       = key_reg;
        status_next    = status_reg;

        if (s1_go)
        begin
            if (s1_end_reg)
            begin
                // Close the frame: publish the result and restart
                out_valid_next = 1'b1;
                if (len == '0)
                begin
                    status_next = STATUS_BAD_FORMAT;
                    key_next    = '0;
                end
                else if (has_par && !parity_upd)
                begin
                    status_next = STATUS_PARITY_FAIL;
                    key_next    = '0;
                end
                else
                begin
                    status_next = STATUS_OK;
                    key_next    = payload;
                end
                pos_next    = '0;
                frame_next  = '0;
                parity_next = 1'b0;
            end
            else
            begin
                // Accumulate; hold the position once it saturates
                frame_next  = frame_upd;
                parity_next = parity_upd;
                if (pos_reg != POS_MAX)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg    <= FMT_26;
            s1_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            frame_reg     <= '0;
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                format_reg <= cfg.frame_format;
            end
            if (frame.ready)
            begin
                s1_valid_reg <= frame.valid;
            end
            pos_reg       <= pos_next;
            frame_reg     <= frame_next;
            parity_reg    <= parity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            s1_bit_reg <= frame.data_bit;
            s1_end_reg <= frame.frame_end;
        end
        key_reg    <= key_next;
        status_reg <= status_next;
    end

    assign key.valid    = out_valid_reg;
    assign key.key_high = key_reg[0:15];
    assign key.key_low  = key_reg[16:FRAME_BITS-1];
    assign key.status   = status_reg;

endmodule

FILE: verif/wiegand_frame_decoder_top_tb.sv
`timescale 1ns / 1ps

module wiegand_frame_decoder_top_tb;

    import wfd_pkg::*;

    // Width of the key slice presented on the output (bytes 0..9)
    localparam int KEY_BITS = 80;

    // Content patterns for generated frames
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_ZEROS  = 2;
    localparam int FILL_SPARSE = 3;

    // Receiver back-pressure patterns
    localparam int RX_ALWAYS  = 0;
    localparam int RX_COIN    = 1;
    localparam int RX_QUARTER = 2;
    localparam int RX_STARVED = 3;

    // Bail out well past the slowest legal run
    localparam int RUN_LIMIT_NS = 5_000_000;

    typedef struct packed {
        logic data_bit;
        logic frame_end;
    } frame_bit_t;

    typedef struct packed {
        logic [15:0]         key_high;
        logic [63:0]         key_low;
        logic [STATUS_W-1:0] status;
    } card_key_t;

    logic clk;
    logic rst_n;

    wfd_cfg_if cfg_ch ();
    wfd_in_if  bit_ch ();
    wfd_out_if key_ch ();

    wiegand_frame_decoder_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .frame (bit_ch),
        .key   (key_ch)
    );

    // Bits waiting for the driver, and keys the decoder still owes us
    frame_bit_t pending_bits[$];
    card_key_t  expected_keys[$];

    // Shadow of the decoder: format register and the frame being assembled.
    // Frame position p is kept at bit 127-p so the store reads MSB-first.
    logic [FMT_W-1:0] cur_format;
    logic [POS_W-1:0] rx_pos;
    logic [127:0]     rx_bits;
    logic             par_lead;
    logic             par_tail;

    int  fail_count;
    int  keys_seen;
    int  stim_count;
    bit  bit_taken;
    bit  cfg_done;

    // Sender burst state and receiver stall state
    int burst_left;
    int gap_left;
    int stall_tick;
    int stall_mode;

    // Visit the extremes first, then interleave the rest
    logic [FMT_W-1:0] format_sweep [8] = '{FMT_26, FMT_UNKNOWN, FMT_80, FMT_32,
                                           FMT_64, FMT_34, FMT_37, FMT_35};

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Format tables, kept independent of the design's own helpers
    // ------------------------------------------------------------------
    function automatic int frame_length(input logic [FMT_W-1:0] f);
        case (f)
            FMT_26:  return 26;
            FMT_32:  return 32;
            FMT_34:  return 34;
            FMT_35:  return 35;
            FMT_37:  return 37;
            FMT_64:  return 64;
            FMT_80:  return 80;
            default: return 0;
        endcase
    endfunction

    function automatic bit parity_framed(input logic [FMT_W-1:0] f);
        return (f == FMT_26) || (f == FMT_34) || (f == FMT_35) || (f == FMT_37);
    endfunction

    // ------------------------------------------------------------------
    // Predictor: absorb one accepted bit, emit the expected key on the
    // final bit of the frame
    // ------------------------------------------------------------------
    task automatic decode_bit(input logic din, input logic last);
        int           len;
        int           keep;
        logic [127:0] word;
        card_key_t    res;
        len = frame_length(cur_format);
        // Store and fold into the parity only bits inside the format length,
        // using the format in force when the bit lands
        if (din && (rx_pos < len))
        begin
            rx_bits[~rx_pos] = 1'b1;
            if (rx_pos < len / 2)
                par_lead = ~par_lead;
            else
                par_tail = ~par_tail;
        end
        // Saturate the position so very long frames cannot wrap it
        if (rx_pos != POS_MAX)
            rx_pos = rx_pos + 1'b1;
        if (last)
        begin
            word       = rx_bits;
            keep       = len;
            res.status = STATUS_OK;
            if (len == 0)
            begin
                res.status = STATUS_BAD_FORMAT;
                word       = '0;
            end
            else if (parity_framed(cur_format))
            begin
                if (par_lead == par_tail)
                begin
                    res.status = STATUS_PARITY_FAIL;
                    word       = '0;
                end
                else
                begin
                    // Strip the leading and trailing parity bits
                    word = word << 1;
                    keep = len - 2;
                end
            end
            if (keep > KEY_BITS)
                keep = KEY_BITS;
            word         = word & ~({128{1'b1}} >> keep);
            res.key_high = word[127:112];
            res.key_low  = word[111:48];
            expected_keys = {expected_keys, res};
            // Start the next frame from scratch
            rx_pos   = '0;
            rx_bits  = '0;
            par_lead = 1'b0;
            par_tail = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < 40)
            $display("%0t ns: key %0d %0s: got %h, want %h",
                     $time, keys_seen, what, got, want);
        fail_count++;
    endtask

    task automatic check_key(input logic [15:0] kh, input logic [63:0] kl,
                             input logic [STATUS_W-1:0] st);
        card_key_t want;
        if (expected_keys.size() == 0)
        begin
            report_mismatch("arrived with none pending", {kh, kl[63:16]}, '0);
        end
        else
        begin
            want = expected_keys.pop_front();
            if (kh !== want.key_high)
                report_mismatch("key_high", 64'(kh), 64'(want.key_high));
            if (kl !== want.key_low)
                report_mismatch("key_low", kl, want.key_low);
            if (st !== want.status)
                report_mismatch("status", 64'(st), 64'(want.status));
        end
        keys_seen++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample every channel at the rising edge. Check the key
    // first; a key leaving at this edge can never belong to a bit taken
    // at the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit_taken = rst_n && bit_ch.valid && bit_ch.ready;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                cur_format = cfg_ch.frame_format;
                cfg_done   = 1'b1;
            end
            if (key_ch.valid && key_ch.ready)
                check_key(key_ch.key_high, key_ch.key_low, key_ch.status);
            if (bit_taken)
                decode_bit(bit_ch.data_bit, bit_ch.frame_end);
        end
    end

    // ------------------------------------------------------------------
    // Driver: hold a bit until its transaction completes, then pull the
    // next one from the queue. Send in bursts with idle gaps between them;
    // some bursts are long with no gap so the line runs at full rate.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        frame_bit_t next_bit;
        if (rst_n && !(bit_ch.valid && !bit_taken))
        begin
            if (gap_left > 0)
            begin
                bit_ch.valid <= 1'b0;
                gap_left--;
            end
            else if (pending_bits.size() == 0)
            begin
                bit_ch.valid <= 1'b0;
            end
            else
            begin
                next_bit = pending_bits.pop_front();
                bit_ch.valid     <= 1'b1;
                bit_ch.data_bit  <= next_bit.data_bit;
                bit_ch.frame_end <= next_bit.frame_end;
                burst_left--;
                if (burst_left <= 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = $urandom_range(20, 60);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 8);
                        gap_left   = $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: pick the stall pattern at random, from always ready
    // down to ready one cycle in eight
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            stall_tick++;
            if (stall_tick % 50 == 0)
                stall_mode = $urandom_range(RX_ALWAYS, RX_STARVED);
            case (stall_mode)
                RX_ALWAYS:  key_ch.ready <= 1'b1;
                RX_COIN:    key_ch.ready <= 1'($urandom_range(0, 1));
                RX_QUARTER: key_ch.ready <= (stall_tick % 4 == 0);
                default:    key_ch.ready <= (stall_tick % 8 == 7);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queue one frame of nbits. When fix_parity is set and the frame has
    // exactly the format length, flip the last bit if needed so the two halves
    // disagree in parity. Leave closed clear to queue a frame with no end.
    task automatic queue_frame(input int nbits, input int fill, input bit fix_parity,
                               input int fmt_bits, input bit closed);
        logic       vec [0:255];
        logic       lead;
        logic       tail;
        frame_bit_t item;
        for (int i = 0; i < nbits; i++)
        begin
            case (fill)
                FILL_ONES:   vec[i] = 1'b1;
                FILL_ZEROS:  vec[i] = 1'b0;
                FILL_SPARSE: vec[i] = ($urandom_range(0, 7) == 0);
                default:     vec[i] = 1'($urandom_range(0, 1));
            endcase
        end
        if (fix_parity && (fmt_bits > 0) && (nbits == fmt_bits))
        begin
            lead = 1'b0;
            tail = 1'b0;
            for (int i = 0; i < nbits; i++)
            begin
                if (i < fmt_bits / 2)
                    lead ^= vec[i];
                else
                    tail ^= vec[i];
            end
            if (lead == tail)
                vec[nbits - 1] = ~vec[nbits - 1];
        end
        for (int i = 0; i < nbits; i++)
        begin
            item.data_bit  = vec[i];
            item.frame_end = closed && (i == nbits - 1);
            pending_bits   = {pending_bits, item};
        end
        stim_count += nbits;
    endtask

    // Wait until every queued bit is sent and every key has come back,
    // then let the pipeline settle
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_bits.size() != 0 || bit_ch.valid || expected_keys.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Drain the decoder, then write the format register
    task automatic program_format(input logic [FMT_W-1:0] f);
        wait_idle();
        @(negedge clk);
        cfg_done = 1'b0;
        cfg_ch.valid        <= 1'b1;
        cfg_ch.frame_format <= f;
        do
            @(negedge clk);
        while (!cfg_done);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Run limit
    // ------------------------------------------------------------------
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [FMT_W-1:0] fmt;
        int               flen;
        int               span;
        int               kind;
        int               fill;
        int               phase;

        // Drive every input to a known value and hold reset
        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.frame_format = FMT_26;
        bit_ch.valid        = 1'b0;
        bit_ch.data_bit     = 1'b0;
        bit_ch.frame_end    = 1'b0;
        key_ch.ready        = 1'b0;

        cur_format    = FMT_26;
        rx_pos        = '0;
        rx_bits       = '0;
        par_lead      = 1'b0;
        par_tail      = 1'b0;
        fail_count    = 0;
        keys_seen     = 0;
        stim_count    = 0;
        bit_taken     = 1'b0;
        cfg_done      = 1'b0;
        burst_left    = 1;
        gap_left      = 0;
        stall_tick    = 0;
        stall_mode    = RX_ALWAYS;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: one-bit frames under the reset format, one with good
        // parity and one that fails it
        queue_frame(1, FILL_ONES, 1'b0, 26, 1'b1);
        queue_frame(1, FILL_ZEROS, 1'b0, 26, 1'b1);
        // Unknown format: key must come back zero with a format error
        program_format(FMT_UNKNOWN);
        queue_frame(3, FILL_ONES, 1'b0, 0, 1'b1);
        // Widest format: a single one lands in the top bit of the key
        program_format(FMT_80);
        queue_frame(1, FILL_ONES, 1'b0, 80, 1'b1);
        program_format(FMT_64);
        queue_frame(2, FILL_RANDOM, 1'b0, 64, 1'b1);
        // Change format in the middle of a frame: start under 26, finish
        // under 37
        program_format(FMT_26);
        queue_frame(5, FILL_RANDOM, 1'b0, 26, 1'b0);
        program_format(FMT_37);
        queue_frame(3, FILL_ONES, 1'b0, 37, 1'b1);

        // Random: mostly well-formed frames for the programmed format,
        // with short, long, bad-parity and overflowing frames mixed in.
        // Each phase ends with a full drain, which also stalls the sender
        // until every key has returned.
        stim_count    = 0;
        phase         = 0;
        while (stim_count < 850)
        begin
            fmt  = (phase < 8) ? format_sweep[phase] : FMT_W'($urandom_range(0, 7));
            program_format(fmt);
            flen = frame_length(fmt);
            repeat ($urandom_range(1, 4))
            begin
                kind = $urandom_range(0, 99);
                fill = $urandom_range(0, 9);
                if (fill > FILL_SPARSE)
                    fill = FILL_RANDOM;
                span = (flen > 0) ? flen : $urandom_range(1, 40);
                if (kind < 60)
                    queue_frame(span, fill, 1'b1, flen, 1'b1);
                else if (kind < 72)
                    queue_frame(span, fill, 1'b0, flen, 1'b1);
                else if (kind < 86)
                    queue_frame($urandom_range(1, span), fill, 1'b0, flen, 1'b1);
                else if (kind < 96)
                    queue_frame(span + $urandom_range(1, 12), fill, 1'b1, flen, 1'b1);
                else
                    queue_frame($urandom_range(128, 140), fill, 1'b0, flen, 1'b1);
            end
            // Sometimes leave a frame open across the next format write
            if ($urandom_range(0, 3) == 0)
                queue_frame($urandom_range(1, 20), FILL_RANDOM, 1'b0, flen, 1'b0);
            phase++;
        end

        wait_idle();
        repeat (6) @(posedge clk);
        if (expected_keys.size() != 0)
            report_mismatch("never arrived", 64'(expected_keys.size()), '0);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
